// ----- hdl/nbc_pkg.sv -----
// ----------------------------------------------------------------------------
// Moore neighbour count package
// Shared widths, register indexes, item codes, window types and the small
// population-count helpers used by the neighbour count stream.
// ----------------------------------------------------------------------------
`default_nettype none

package nbc_pkg;

   // Configuration register file.
   localparam int ROWS_W      = 16;
   localparam int COLS_W      = 11;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_COLS = 1'b1;

   localparam logic [ROWS_W-1:0] GRID_ROWS_RESET = 16'd30;
   localparam logic [COLS_W-1:0] GRID_COLS_RESET = 11'd30;

   // Input item kinds.
   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   // Result width and result queue sizing.
   localparam int COUNT_W    = 4;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = 3;
   localparam int FIFO_CNT_W = 4;

   // A window column: bit 0 is the oldest row, bit 2 the newest.
   typedef logic [2:0] column_type;

   // Selects the rows above and below in the centre column.
   localparam column_type MID_MASK = 3'b101;

   typedef struct packed {
      logic shift;
      logic clear;
      logic load;
   } win_ctrl_type;

   typedef struct packed {
      logic [COUNT_W-1:0] neighbor_count;
      logic               last_of_frame;
   } result_type;

   typedef struct packed {
      logic       valid0;
      result_type result0;
      logic       valid1;
      result_type result1;
   } push_type;

   function automatic logic [1:0] pop3(input column_type v);
      return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
   endfunction

   // Count for a cell with both side columns present.
   function automatic logic [COUNT_W-1:0] count_full(input column_type l,
                                                     input column_type m,
                                                     input column_type r);
      return COUNT_W'(pop3(l)) + COUNT_W'(pop3(r)) + COUNT_W'(pop3(m & MID_MASK));
   endfunction

   // Count for the last cell of a row: the right-hand column is off the grid.
   function automatic logic [COUNT_W-1:0] count_edge(input column_type m,
                                                     input column_type r);
      return COUNT_W'(pop3(m)) + COUNT_W'(pop3(r & MID_MASK));
   endfunction

endpackage

`default_nettype wire

// ----- hdl/nbc_line_store.sv -----
// ----------------------------------------------------------------------------
// Row store
// One bit per column, one write port and two registered read ports with
// write-through on an address match.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc_line_store #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              wr_data,
   input  logic [ADDR_W-1:0] rd_addr_p,
   input  logic [ADDR_W-1:0] rd_addr_q,
   output logic              rd_data_p,
   output logic              rd_data_q
);

   logic store_ff [DEPTH];
   logic rd_data_p_ff;
   logic rd_data_q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // A read in the same cycle as a write to that column returns the new bit.
   always_ff @(posedge clock) begin
      rd_data_p_ff <= (wr_en && (wr_addr == rd_addr_p)) ? wr_data : store_ff[rd_addr_p];
      rd_data_q_ff <= (wr_en && (wr_addr == rd_addr_q)) ? wr_data : store_ff[rd_addr_q];
   end

   assign rd_data_p = rd_data_p_ff;
   assign rd_data_q = rd_data_q_ff;

endmodule

`default_nettype wire

// ----- hdl/nbc_window_cell.sv -----
// ----------------------------------------------------------------------------
// Window column cell
// Holds one three-row column of the 3x3 window and takes its neighbour's
// column on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc_window_cell (
   input  logic                      clock,
   input  nbc_pkg::win_ctrl_type     ctrl,
   input  nbc_pkg::column_type       shift_in,
   input  nbc_pkg::column_type       load_value,
   output nbc_pkg::column_type       col_q,
   output nbc_pkg::column_type       col_next
);

   nbc_pkg::column_type col_ff;
   nbc_pkg::column_type col_in;

   always_comb begin
      col_in = col_ff;
      if (ctrl.load) begin
         col_in = load_value;
      end else if (ctrl.shift) begin
         col_in = ctrl.clear ? '0 : shift_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
   end

   assign col_q    = col_ff;
   assign col_next = col_in;

endmodule

`default_nettype wire

// ----- hdl/nbc_result_fifo.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results a cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module nbc_result_fifo (
   input  logic                             clock,
   input  logic                             reset,
   input  nbc_pkg::push_type                push,
   input  logic                             pop,
   output nbc_pkg::result_type              head,
   output logic                             not_empty,
   output logic [nbc_pkg::FIFO_CNT_W-1:0]   count
);

   nbc_pkg::result_type entry_ff [nbc_pkg::FIFO_DEPTH];

   logic [nbc_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [nbc_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [nbc_pkg::FIFO_PTR_W-1:0] wr_ptr_second;
   logic [nbc_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic [1:0]                     push_n;

   always_comb begin
      push_n        = {1'b0, push.valid0} + {1'b0, push.valid1};
      wr_ptr_second = wr_ptr_ff + nbc_pkg::FIFO_PTR_W'(1);
      wr_ptr_in     = wr_ptr_ff + nbc_pkg::FIFO_PTR_W'(push_n);
      rd_ptr_in     = rd_ptr_ff + nbc_pkg::FIFO_PTR_W'(pop);
      count_in      = count_ff + nbc_pkg::FIFO_CNT_W'(push_n) - nbc_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         entry_ff[wr_ptr_ff] <= push.result0;
      end
      if (push.valid1) begin
         entry_ff[wr_ptr_second] <= push.result1;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

`default_nettype wire

// ----- hdl/moore_neighbor_count_stream.sv -----
// ----------------------------------------------------------------------------
// Moore neighbour count stream
// Counts the live cells among the eight neighbours of every cell of a binary
// grid that arrives in raster order.
// ----------------------------------------------------------------------------
// Usage.
// Grid cells enter on the req_ channel, one per transfer, in raster order
// with req_kind set to cell. Counts leave on the rsp_ channel in raster
// order. A cell's count is produced once the cell below and to the right of
// it has arrived, so row 0 produces nothing, later cells produce the count
// of the cell up and to the left, and the last cell of a row also produces
// the count of the cell directly above it. After the final cell of a frame
// the last row's counts are released one per drain transfer; the drain that
// releases the final count raises rsp_last_of_frame and the block starts the
// next frame at row 0. Cells sent while drains are pending, and drains sent
// with no frame loaded, are dropped without a result.
// A req_ transfer's results reach rsp_ through the stage register and the
// result queue. One item is taken per cycle while req_stall is low: the row
// store read, then in the second stage the window shift and count, then an
// eight-entry result queue. req_stall rises while the queue, once it has
// taken the results of the item in the second stage, would have fewer than
// two free entries, so a receiver that stalls rsp_ back-pressures req_ once
// the queue fills. Synchronous reset empties the pipeline and the queue and
// sets the grid size to 30 rows by 30 columns. The row stores are not
// cleared; every entry is written before it is read within a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module moore_neighbor_count_stream #(
   parameter int MAX_COLS = 1024
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_kind,
   input  logic                               req_cell_value,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [nbc_pkg::COUNT_W-1:0]        rsp_neighbor_count,
   output logic                               rsp_last_of_frame,

   input  logic                               csr_write,
   input  logic [nbc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nbc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Column address width, width able to hold MAX_COLS itself, and the width
   // in which the configured column count is compared against MAX_COLS.
   localparam int ADDR_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int CCNT_W  = $clog2(MAX_COLS + 1);
   localparam int CMP_W   = (CCNT_W > nbc_pkg::COLS_W) ? CCNT_W : nbc_pkg::COLS_W;
   localparam int STALL_W = nbc_pkg::FIFO_CNT_W + 1;

   // Everything the second pipeline stage needs to know about an item.
   typedef struct packed {
      logic              drain;
      logic              cell_value;
      logic [ADDR_W-1:0] col;
      logic              up1_en;
      logic              up2_en;
      logic              emit_a;
      logic              emit_b;
      logic              clear;
      logic              load;
      logic              left_en;
      logic              right_en;
      logic              first;
      logic              last;
      logic              rows_two;
   } stage_type;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [nbc_pkg::ROWS_W-1:0] grid_rows_ff, grid_rows_in;
   logic [nbc_pkg::COLS_W-1:0] grid_cols_ff, grid_cols_in;

   always_comb begin
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      if (csr_write) begin
         case (csr_index)
            nbc_pkg::CSR_GRID_ROWS: grid_rows_in = csr_wdata[nbc_pkg::ROWS_W-1:0];
            nbc_pkg::CSR_GRID_COLS: grid_cols_in = csr_wdata[nbc_pkg::COLS_W-1:0];
            default: begin
               grid_rows_in = grid_rows_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= nbc_pkg::GRID_ROWS_RESET;
         grid_cols_ff <= nbc_pkg::GRID_COLS_RESET;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
      end
   end

   // Effective sizes: a zero size acts as one, and the column count is capped
   // at the row store depth. Sizes are used as soon as they are written.
   logic [CMP_W-1:0]           cols_wide;
   logic [CCNT_W-1:0]          cols_eff;
   logic [ADDR_W-1:0]          last_col;
   logic [nbc_pkg::ROWS_W-1:0] last_row;
   logic                       rows_two;

   always_comb begin
      cols_wide = CMP_W'(grid_cols_ff);
      if (cols_wide == '0) begin
         cols_eff = CCNT_W'(1);
      end else if (cols_wide > CMP_W'(MAX_COLS)) begin
         cols_eff = CCNT_W'(MAX_COLS);
      end else begin
         cols_eff = CCNT_W'(cols_wide);
      end
      last_col = ADDR_W'(cols_eff - CCNT_W'(1));
      last_row = (grid_rows_ff == '0) ? '0 : grid_rows_ff - nbc_pkg::ROWS_W'(1);
      rows_two = (grid_rows_ff[nbc_pkg::ROWS_W-1:1] != '0);
   end

   // ------------------------------------------------------------------------
   // First stage: position counters and row store reads
   // ------------------------------------------------------------------------
   logic [nbc_pkg::ROWS_W-1:0] input_row_ff, input_row_in;
   logic [ADDR_W-1:0]          input_col_ff, input_col_in;
   logic [ADDR_W-1:0]          drain_col_ff, drain_col_in;
   logic                       frame_loaded_ff, frame_loaded_in;

   logic              req_accept;
   logic              do_cell;
   logic              do_drain;
   logic [ADDR_W-1:0] col;
   logic              row_end;
   logic              frame_end;
   logic [ADDR_W-1:0] drain_pos;
   logic              drain_first;
   logic              drain_last;
   logic              drain_load;
   logic [ADDR_W-1:0] rd_addr_p;
   logic [ADDR_W-1:0] rd_addr_q;

   stage_type stage_ff, stage_in;
   logic      b_valid_ff, b_valid_in;

   always_comb begin
      req_accept = req_valid && !req_stall;
      do_cell    = req_accept && (req_kind == nbc_pkg::KIND_CELL) && !frame_loaded_ff;
      do_drain   = req_accept && (req_kind == nbc_pkg::KIND_DRAIN) && frame_loaded_ff;

      row_end   = (input_col_ff >= last_col);
      col       = row_end ? last_col : input_col_ff;
      frame_end = row_end && (input_row_ff >= last_row);

      // A drain normally slides the window by one column and only needs the
      // column to its right. The first drain, and one whose position was cut
      // back by a smaller column count, reload the whole window instead.
      drain_last  = (drain_col_ff >= last_col);
      drain_pos   = drain_last ? last_col : drain_col_ff;
      drain_first = (drain_pos == '0);
      drain_load  = drain_first || (drain_col_ff > last_col);

      rd_addr_q = (req_kind == nbc_pkg::KIND_DRAIN) ? drain_pos : col;
      rd_addr_p = (drain_load && !drain_first) ? drain_pos - ADDR_W'(1)
                                               : drain_pos + ADDR_W'(1);

      input_row_in    = input_row_ff;
      input_col_in    = input_col_ff;
      drain_col_in    = drain_col_ff;
      frame_loaded_in = frame_loaded_ff;
      if (do_cell) begin
         input_col_in = row_end ? '0 : col + ADDR_W'(1);
         if (row_end) begin
            if (frame_end) begin
               input_row_in    = '0;
               frame_loaded_in = 1'b1;
               drain_col_in    = '0;
            end else begin
               input_row_in = input_row_ff + nbc_pkg::ROWS_W'(1);
            end
         end
      end
      if (do_drain) begin
         if (drain_last) begin
            drain_col_in    = '0;
            frame_loaded_in = 1'b0;
         end else begin
            drain_col_in = drain_pos + ADDR_W'(1);
         end
      end

      b_valid_in          = do_cell || do_drain;
      stage_in.drain      = (req_kind == nbc_pkg::KIND_DRAIN);
      stage_in.cell_value = req_cell_value;
      stage_in.col        = col;
      stage_in.up1_en     = (input_row_ff != '0);
      stage_in.up2_en     = (input_row_ff[nbc_pkg::ROWS_W-1:1] != '0);
      stage_in.emit_a     = (input_row_ff != '0) && (col != '0);
      stage_in.emit_b     = (input_row_ff != '0) && row_end;
      stage_in.clear      = (col == '0);
      stage_in.load       = drain_load;
      stage_in.left_en    = !drain_first;
      stage_in.right_en   = !drain_last;
      stage_in.first      = drain_first;
      stage_in.last       = drain_last;
      stage_in.rows_two   = rows_two;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_row_ff    <= '0;
         input_col_ff    <= '0;
         drain_col_ff    <= '0;
         frame_loaded_ff <= 1'b0;
         b_valid_ff      <= 1'b0;
      end else begin
         input_row_ff    <= input_row_in;
         input_col_ff    <= input_col_in;
         drain_col_ff    <= drain_col_in;
         frame_loaded_ff <= frame_loaded_in;
         b_valid_ff      <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   // ------------------------------------------------------------------------
   // Row stores: the older one holds the row before last, the newer one the
   // last row. A cell moves the newer bit of its column down into the older
   // store and puts itself into the newer store.
   // ------------------------------------------------------------------------
   logic store_wr_en;
   logic old_p, old_q, new_p, new_q;
   logic up1, up2;

   assign store_wr_en = b_valid_ff && !stage_ff.drain;
   assign up2         = old_q && stage_ff.up2_en;
   assign up1         = new_q && stage_ff.up1_en;

   nbc_line_store #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (ADDR_W)
   ) u_older_store (
      .clock     (clock),
      .wr_en     (store_wr_en),
      .wr_addr   (stage_ff.col),
      .wr_data   (up1),
      .rd_addr_p (rd_addr_p),
      .rd_addr_q (rd_addr_q),
      .rd_data_p (old_p),
      .rd_data_q (old_q)
   );

   nbc_line_store #(
      .DEPTH  (MAX_COLS),
      .ADDR_W (ADDR_W)
   ) u_newer_store (
      .clock     (clock),
      .wr_en     (store_wr_en),
      .wr_addr   (stage_ff.col),
      .wr_data   (stage_ff.cell_value),
      .rd_addr_p (rd_addr_p),
      .rd_addr_q (rd_addr_q),
      .rd_data_p (new_p),
      .rd_data_q (new_q)
   );

   // ------------------------------------------------------------------------
   // Second stage: the 3x3 window as a chain of three column cells. New
   // columns enter on the right and move one cell left per shift.
   // ------------------------------------------------------------------------
   nbc_pkg::column_type cell_col;
   nbc_pkg::column_type p_col;
   nbc_pkg::column_type q_col;
   nbc_pkg::column_type right_in;
   nbc_pkg::column_type left_load, mid_load, right_load;
   nbc_pkg::win_ctrl_type side_ctrl;
   nbc_pkg::win_ctrl_type right_ctrl;
   nbc_pkg::column_type left_q, mid_q, right_q;
   nbc_pkg::column_type left_next, mid_next, right_next;

   always_comb begin
      cell_col = {stage_ff.cell_value, up1, up2};
      // During drains the own row of the counted cell is the newer store;
      // it goes to the middle bit so the same count formula applies.
      p_col = {1'b0, new_p, old_p && stage_ff.rows_two};
      q_col = {1'b0, new_q, old_q && stage_ff.rows_two};

      right_in   = stage_ff.drain ? (stage_ff.right_en ? p_col : '0) : cell_col;
      left_load  = stage_ff.left_en ? p_col : '0;
      mid_load   = q_col;
      right_load = (stage_ff.first && stage_ff.right_en) ? p_col : '0;

      side_ctrl  = '0;
      right_ctrl = '0;
      if (b_valid_ff) begin
         if (!stage_ff.drain) begin
            // The first column of a row starts from an empty window.
            side_ctrl.shift  = 1'b1;
            side_ctrl.clear  = stage_ff.clear;
            right_ctrl.shift = 1'b1;
         end else if (stage_ff.load) begin
            side_ctrl.load  = 1'b1;
            right_ctrl.load = 1'b1;
         end else begin
            side_ctrl.shift  = 1'b1;
            right_ctrl.shift = 1'b1;
         end
      end
   end

   nbc_window_cell u_left_cell (
      .clock      (clock),
      .ctrl       (side_ctrl),
      .shift_in   (mid_q),
      .load_value (left_load),
      .col_q      (left_q),
      .col_next   (left_next)
   );

   nbc_window_cell u_mid_cell (
      .clock      (clock),
      .ctrl       (side_ctrl),
      .shift_in   (right_q),
      .load_value (mid_load),
      .col_q      (mid_q),
      .col_next   (mid_next)
   );

   nbc_window_cell u_right_cell (
      .clock      (clock),
      .ctrl       (right_ctrl),
      .shift_in   (right_in),
      .load_value (right_load),
      .col_q      (right_q),
      .col_next   (right_next)
   );

   // ------------------------------------------------------------------------
   // Counts and result queue
   // ------------------------------------------------------------------------
   logic [nbc_pkg::COUNT_W-1:0]    count_a;
   logic [nbc_pkg::COUNT_W-1:0]    count_b;
   nbc_pkg::push_type              push;
   logic [1:0]                     b_push_count;
   logic                           rsp_accept;
   nbc_pkg::result_type            fifo_head;
   logic                           fifo_not_empty;
   logic [nbc_pkg::FIFO_CNT_W-1:0] fifo_count;
   logic [STALL_W-1:0]             fifo_need;

   always_comb begin
      count_a = nbc_pkg::count_full(left_next, mid_next, right_next);
      count_b = nbc_pkg::count_edge(mid_next, right_next);

      push = '0;
      if (b_valid_ff) begin
         if (stage_ff.drain) begin
            push.valid0                 = 1'b1;
            push.result0.neighbor_count = count_a;
            push.result0.last_of_frame  = stage_ff.last;
         end else begin
            // Cell up and to the left first, then at a row end the cell
            // directly above.
            push.valid0                 = stage_ff.emit_a || stage_ff.emit_b;
            push.result0.neighbor_count = stage_ff.emit_a ? count_a : count_b;
            push.valid1                 = stage_ff.emit_a && stage_ff.emit_b;
            push.result1.neighbor_count = count_b;
         end
      end
      b_push_count = {1'b0, push.valid0} + {1'b0, push.valid1};

      // Room must remain for this stage's results and two from a new item.
      fifo_need = STALL_W'(fifo_count) + STALL_W'(b_push_count) + STALL_W'(2);
      req_stall = reset || (fifo_need > STALL_W'(nbc_pkg::FIFO_DEPTH));

      rsp_accept = fifo_not_empty && !rsp_stall;
   end

   nbc_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .head      (fifo_head),
      .not_empty (fifo_not_empty),
      .count     (fifo_count)
   );

   assign rsp_valid          = fifo_not_empty;
   assign rsp_neighbor_count = fifo_head.neighbor_count;
   assign rsp_last_of_frame  = fifo_head.last_of_frame;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_cell_dropped_while_loaded: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_kind == nbc_pkg::KIND_CELL) && frame_loaded_ff) |=> !b_valid_ff)
      else $error("cell transfer entered the pipeline while drains were pending");

   a_loaded_counters_home: assert property (@(posedge clock) disable iff (reset)
      frame_loaded_ff |-> ((input_col_ff == '0) && (input_row_ff == '0)))
      else $error("frame loaded with the cell position away from the origin");

   a_drain_single_result: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && stage_ff.drain) |-> (push.valid0 && !push.valid1))
      else $error("drain did not produce exactly one result");

   a_queue_bounded: assert property (@(posedge clock) disable iff (reset)
      (STALL_W'(fifo_count) + STALL_W'(b_push_count)) <= STALL_W'(nbc_pkg::FIFO_DEPTH))
      else $error("result queue would overflow");

   a_window_cleared_at_row_start: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && !stage_ff.drain && stage_ff.clear)
         |=> ((left_q == '0) && (mid_q == '0)))
      else $error("window side columns not cleared at the start of a row");

endmodule

`default_nettype wire

// ----- dv/moore_neighbor_count_stream_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moore neighbour count stream testbench
// Streams binary grid frames through the block in raster order, with drain
// transfers to release the last row. Each accepted transfer is run through a
// local bit-accurate neighbour counter, and every count leaving the block is
// checked against the oldest outstanding prediction. Grid sizes change
// between phases, and in two places part-way through a frame.
// ----------------------------------------------------------------------------

module moore_neighbor_count_stream_tb;

   localparam int ROW_STORE_DEPTH = 1024;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 8;
   localparam int HOLD_CYCLES     = 400;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 72;
   localparam int TAIL_COLS       = 6;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_type;

   typedef struct packed {
      logic kind;
      logic alive;
   } grid_item_type;

   // Block ports. Every input holds a known value from time zero.
   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_stall;
   logic                            req_kind       = nbc_pkg::KIND_CELL;
   logic                            req_cell_value = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall      = 1'b0;
   logic [nbc_pkg::COUNT_W-1:0]     rsp_neighbor_count;
   logic                            rsp_last_of_frame;
   logic                            csr_write      = 1'b0;
   logic [nbc_pkg::CSR_INDEX_W-1:0] csr_index      = nbc_pkg::CSR_GRID_ROWS;
   logic [nbc_pkg::CSR_DATA_W-1:0]  csr_wdata      = '0;

   // Local copy of the counter state. The row arrays start at zero, but the
   // stimulus never reads an entry that has not been written since reset.
   bit          prev2_row [ROW_STORE_DEPTH];
   bit          prev1_row [ROW_STORE_DEPTH];
   logic [8:0]  window3x3     = '0;
   int unsigned row_pos       = 0;
   int unsigned col_pos       = 0;
   int unsigned drain_pos     = 0;
   bit          frame_pending = 1'b0;
   int unsigned rows_setting  = nbc_pkg::GRID_ROWS_RESET;
   int unsigned cols_setting  = nbc_pkg::GRID_COLS_RESET;

   grid_item_type        pending_items[$];
   nbc_pkg::result_type  expected_counts[$];

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int          error_count    = 0;
   int          cycle_count    = 0;

   // Long receiver hold-off, counted in its own process below.
   logic        hold_armed = 1'b0;
   logic        hold_done  = 1'b0;
   int          hold_count = 0;
   logic        receiver_held;

   moore_neighbor_count_stream dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_cell_value     (req_cell_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // Neighbour count prediction
   // ------------------------------------------------------------------------

   // A row count of zero behaves as one.
   function automatic int unsigned rows_effective();
      return (rows_setting == 0) ? 1 : rows_setting;
   endfunction

   // A column count of zero behaves as one, and anything beyond the row
   // store depth is clipped to it.
   function automatic int unsigned cols_effective();
      int unsigned c;
      c = (cols_setting == 0) ? 1 : cols_setting;
      return (c > ROW_STORE_DEPTH) ? ROW_STORE_DEPTH : c;
   endfunction

   function automatic int unsigned live_cells(logic [2:0] column);
      return int'(column[0]) + int'(column[1]) + int'(column[2]);
   endfunction

   function automatic void add_expected(int unsigned count, logic is_last);
      nbc_pkg::result_type r;
      r.neighbor_count = nbc_pkg::COUNT_W'(count);
      r.last_of_frame  = is_last;
      expected_counts.push_back(r);
   endfunction

   // A grid cell enters the window. Once the frame is complete, further
   // cells are dropped until the last row has been drained.
   function automatic void advance_on_cell(logic alive);
      int unsigned cols, rows, col;
      logic        up1, up2;
      logic [2:0]  left_col, mid_col, right_col;
      cols = cols_effective();
      rows = rows_effective();
      if (frame_pending)
         return;
      col = (col_pos >= cols) ? cols - 1 : col_pos;
      up2 = (row_pos >= 2) ? prev2_row[col] : 1'b0;
      up1 = (row_pos >= 1) ? prev1_row[col] : 1'b0;
      prev2_row[col] = up1;
      prev1_row[col] = alive;
      // Column bit 0 is the oldest row; the window restarts at each row.
      if (col == 0)
         window3x3 = '0;
      window3x3 = {alive, up1, up2, window3x3[8:3]};
      left_col  = window3x3[2:0];
      mid_col   = window3x3[5:3];
      right_col = window3x3[8:6];
      if (row_pos >= 1) begin
         // The cell up and to the left now has its whole neighbourhood.
         if (col >= 1)
            add_expected(live_cells(left_col) + live_cells(right_col)
                         + live_cells(mid_col & nbc_pkg::MID_MASK), 1'b0);
         // At a row end the cell directly above is complete as well.
         if (col + 1 >= cols)
            add_expected(live_cells(mid_col)
                         + live_cells(right_col & nbc_pkg::MID_MASK), 1'b0);
      end
      if (col + 1 >= cols) begin
         col_pos = 0;
         if (row_pos + 1 >= rows) begin
            row_pos       = 0;
            frame_pending = 1'b1;
            drain_pos     = 0;
         end else begin
            row_pos = row_pos + 1;
         end
      end else begin
         col_pos = col + 1;
      end
   endfunction

   // A drain releases the next count of the last row, whose lower
   // neighbours all lie off the grid.
   function automatic void advance_on_drain();
      int unsigned cols, rows, d, c, sum;
      logic        is_last;
      cols = cols_effective();
      rows = rows_effective();
      if (!frame_pending)
         return;
      d   = (drain_pos >= cols) ? cols - 1 : drain_pos;
      sum = 0;
      for (c = (d == 0) ? 0 : d - 1; c <= d + 1 && c < cols; c++) begin
         if (rows >= 2)
            sum += prev2_row[c];
         if (c != d)
            sum += prev1_row[c];
      end
      is_last = (d + 1 >= cols);
      add_expected(sum, is_last);
      if (is_last) begin
         drain_pos     = 0;
         frame_pending = 1'b0;
      end else begin
         drain_pos = d + 1;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   function automatic void note_mismatch(string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endfunction

   function automatic void check_count(logic [nbc_pkg::COUNT_W-1:0] count, logic is_last);
      nbc_pkg::result_type want;
      if (expected_counts.size() == 0) begin
         note_mismatch($sformatf("count %0d, last_of_frame %0b arrived with none outstanding",
                                 count, is_last));
         return;
      end
      want = expected_counts.pop_front();
      if (count !== want.neighbor_count || is_last !== want.last_of_frame)
         note_mismatch($sformatf("count exp %0d got %0d, last_of_frame exp %0b got %0b",
                                 want.neighbor_count, count, want.last_of_frame, is_last));
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers the queued items one transfer at a time. The prediction
   // is advanced at the edge where a transfer is accepted. A stalled item is
   // held unchanged; a new item is only offered once the slot is free.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_kind == nbc_pkg::KIND_DRAIN)
               advance_on_drain();
            else
               advance_on_cell(req_cell_value);
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid      <= 1'b1;
               req_kind       <= pending_items[0].kind;
               req_cell_value <= pending_items[0].alive;
               pending_items.delete(0);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each count transfer and decides the next stall.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_count(rsp_neighbor_count, rsp_last_of_frame);
         rsp_stall <= receiver_held || ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // The hold-off runs once after arming and ends when the hold counter reaches its limit.
   always @(posedge clock) begin
      if (reset) begin
         hold_count <= 0;
         hold_done  <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         if (hold_count == HOLD_CYCLES - 1)
            hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end
   end

   assign receiver_held = hold_armed && !hold_done;

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   function automatic void set_idling(idling_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 55;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 55;
         end
         default: begin
            send_idle_pct  = 19;
            recv_stall_pct = 19;
         end
      endcase
   endfunction

   function automatic void queue_cell(logic alive);
      grid_item_type it;
      it.kind  = nbc_pkg::KIND_CELL;
      it.alive = alive;
      pending_items.push_back(it);
   endfunction

   // The cell value of a drain is ignored by the block, so it is random.
   function automatic void queue_drain();
      grid_item_type it;
      it.kind  = nbc_pkg::KIND_DRAIN;
      it.alive = $urandom_range(0, 1);
      pending_items.push_back(it);
   endfunction

   function automatic void queue_cells(int unsigned count, int unsigned live_pct);
      repeat (count)
         queue_cell($urandom_range(0, 99) < live_pct);
   endfunction

   // With noise on, stray cells are slipped in while drains are pending;
   // the block must drop them.
   function automatic void queue_drains(int unsigned count, bit noisy);
      repeat (count) begin
         if (noisy && $urandom_range(0, 3) == 0)
            queue_cell($urandom_range(0, 1));
         queue_drain();
      end
   endfunction

   // One whole frame with a random density; now and then a stray drain
   // precedes it, while no frame is loaded, and stray cells follow it.
   function automatic void queue_frame(int unsigned rows, int unsigned cols);
      bit noisy;
      noisy = ($urandom_range(0, 4) == 0);
      if (noisy)
         queue_drain();
      queue_cells(rows * cols, $urandom_range(0, 100));
      queue_drains(cols, noisy);
   endfunction

   // Registers are only written while nothing is in flight, so the local
   // settings can follow the write at once.
   task automatic write_reg(logic [nbc_pkg::CSR_INDEX_W-1:0] reg_index, int unsigned value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= nbc_pkg::CSR_DATA_W'(value);
      if (reg_index == nbc_pkg::CSR_GRID_ROWS)
         rows_setting = value & 32'hFFFF;
      else
         cols_setting = value & 32'h7FF;
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Dropped items produce nothing, so the task waits further after the last
   // count, for the pipeline to empty.
   task automatic wait_until_idle();
      while (pending_items.size() != 0 || req_valid || expected_counts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic run_phase(int unsigned rows_value, int unsigned cols_value,
                            int unsigned target);
      int unsigned rows, cols, queued;
      write_reg(nbc_pkg::CSR_GRID_ROWS, rows_value);
      write_reg(nbc_pkg::CSR_GRID_COLS, cols_value);
      rows   = rows_effective();
      cols   = cols_effective();
      queued = 0;
      while (queued < target) begin
         queue_frame(rows, cols);
         queued += rows * cols + cols;
      end
      wait_until_idle();
   endtask

   // ------------------------------------------------------------------------
   // Run-time limit
   // ------------------------------------------------------------------------
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d counts outstanding",
               cycle_count, expected_counts.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int unsigned phase_rows, phase_cols;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A single-row frame from a zero row count: a drain with no frame
      // loaded is dropped, the cells give nothing, a cell sent while drains
      // are pending is dropped, and the second drain ends the frame.
      write_reg(nbc_pkg::CSR_GRID_ROWS, 0);
      write_reg(nbc_pkg::CSR_GRID_COLS, 2);
      queue_drain();
      queue_cell(1'b1);
      queue_cell(1'b1);
      queue_cell(1'b0);
      queue_drain();
      queue_drain();
      wait_until_idle();

      // A zero column count behaves as one column: every cell ends a row.
      write_reg(nbc_pkg::CSR_GRID_ROWS, 3);
      write_reg(nbc_pkg::CSR_GRID_COLS, 0);
      queue_cell(1'b1);
      queue_cell(1'b0);
      queue_cell(1'b1);
      queue_drain();
      wait_until_idle();

      // All cells alive, so the centre count reaches eight. The frame starts
      // at the largest row count, which is cut to three after two rows.
      write_reg(nbc_pkg::CSR_GRID_ROWS, 16'hFFFF);
      write_reg(nbc_pkg::CSR_GRID_COLS, 3);
      queue_cells(6, 100);
      wait_until_idle();
      write_reg(nbc_pkg::CSR_GRID_ROWS, 3);
      queue_cells(3, 100);
      queue_drains(3, 1'b0);
      wait_until_idle();

      // Random frames, cycling through the idling patterns. The fifth phase
      // holds the receiver off for a long stretch while items keep coming,
      // so the result queue fills and the block stalls its input.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idling(idling_type'(phase % 4));
         case (phase)
            0: begin
               phase_rows = 4;
               phase_cols = 5;
            end
            1: begin
               phase_rows = 1;
               phase_cols = 7;
            end
            2: begin
               phase_rows = 6;
               phase_cols = 1;
            end
            3: begin
               phase_rows = 5;
               phase_cols = 8;
            end
            4: begin
               phase_rows = 8;
               phase_cols = 16;
               @(posedge clock);
               hold_armed <= 1'b1;
               @(negedge clock);
            end
            5: begin
               phase_rows = 2;
               phase_cols = 3;
            end
            default: begin
               phase_rows = $urandom_range(1, 7);
               phase_cols = $urandom_range(1, 12);
            end
         endcase
         run_phase(phase_rows, phase_cols, PHASE_ITEMS);
      end

      // An oversized column count is clipped to the row store depth, so the
      // first cells of row 0 do not end it. The column count then shrinks
      // mid-row: the next cell is folded onto the new last column and ends
      // the row, and one more row with its drains completes the frame.
      set_idling(IDLE_BOTH);
      write_reg(nbc_pkg::CSR_GRID_ROWS, 16'hFFFF);
      write_reg(nbc_pkg::CSR_GRID_COLS, 2047);
      queue_cells(TAIL_COLS, $urandom_range(0, 100));
      wait_until_idle();
      write_reg(nbc_pkg::CSR_GRID_COLS, TAIL_COLS);
      write_reg(nbc_pkg::CSR_GRID_ROWS, 2);
      queue_cells(TAIL_COLS + 1, $urandom_range(0, 100));
      queue_drains(TAIL_COLS, 1'b1);
      wait_until_idle();

      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
